@@ hdl/sacc_pkg.sv @@
// ----------------------------------------------------------------------------
// sacc_pkg: shared types and constants of the sparse accumulator
// field widths, opcode codes, stream packing and control structs
// ----------------------------------------------------------------------------
package sacc_pkg;

  localparam int KEY_W       = 10;  // key field width
  localparam int WEIGHT_W    = 16;  // weight field width
  localparam int ENTRY_TOT_W = 32;  // entry_total field width
  localparam int DIST_W      = 11;  // distinct_count field width
  localparam int WIDE_W      = 17;  // holds any key range value up to 65536
  localparam int WIDE_CNT_W  = 64;  // holds any count width

  localparam int IN_DATA_W  = 32;   // key, weight, zero fill
  localparam int OUT_DATA_W = 56;   // key, total, distinct, empty, saturated, fill

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [KEY_W-1:0]    key;
    logic [WEIGHT_W-1:0] weight;
  } item_t;

  typedef struct packed {
    logic cnt_we;       // count store write
    logic list_we;      // append to the seen list
    logic entry_valid;  // drain popped an entry
    logic sat;          // accumulate clipped at maximum
  } ctrl_t;

endpackage

@@ hdl/sacc_exec.sv @@
// ----------------------------------------------------------------------------
// sacc_exec: execute logic of the sparse accumulator
// saturating add, list push/pop bookkeeping and result fields for one item
// ----------------------------------------------------------------------------
module sacc_exec #(
  parameter int KEY_RANGE  = 1024,
  parameter int COUNT_BITS = 32,
  parameter int ADDR_W     = $clog2(KEY_RANGE),
  parameter int TOT_W      = $clog2(KEY_RANGE + 1)
) (
  input  sacc_pkg::item_t                   item_i,
  input  logic [COUNT_BITS-1:0]             old_count_i,
  input  logic [TOT_W-1:0]                  total_i,
  input  logic [sacc_pkg::KEY_W-1:0]        top_key_i,
  input  logic [sacc_pkg::KEY_W-1:0]        list_rd_i,
  output sacc_pkg::ctrl_t                   ctrl_o,
  output logic [ADDR_W-1:0]                 cnt_addr_o,
  output logic [COUNT_BITS-1:0]             cnt_data_o,
  output logic [ADDR_W-1:0]                 list_addr_o,
  output logic [TOT_W-1:0]                  total_o,
  output logic [sacc_pkg::KEY_W-1:0]        top_key_o,
  output logic [sacc_pkg::KEY_W-1:0]        entry_key_o,
  output logic [COUNT_BITS-1:0]             entry_total_o
);
  import sacc_pkg::*;

  localparam int SUM_W = ((COUNT_BITS > WEIGHT_W) ? COUNT_BITS : WEIGHT_W) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [WIDE_W-1:0]     key_wide;
  logic [WIDE_W-1:0]     top_wide;
  logic                  accum_ok;
  logic                  pop_ok;
  logic                  append;
  logic [SUM_W-1:0]      sum;
  logic                  clip;
  logic [COUNT_BITS-1:0] new_count;

  assign key_wide  = WIDE_W'(item_i.key);
  assign top_wide  = WIDE_W'(top_key_i);
  assign accum_ok  = (item_i.op == OP_ACCUM) && (item_i.weight != '0) &&
                     (key_wide < WIDE_W'(KEY_RANGE));
  assign pop_ok    = (item_i.op == OP_DRAIN) && (total_i != '0);
  assign sum       = SUM_W'(old_count_i) + SUM_W'(item_i.weight);
  assign clip      = sum > SUM_W'(CNT_MAX);
  assign new_count = clip ? CNT_MAX : sum[COUNT_BITS-1:0];
  // first hit on a key puts it on the list
  assign append    = accum_ok && (old_count_i == '0) && (total_i < TOT_W'(KEY_RANGE));

  always_comb begin
    ctrl_o.cnt_we      = accum_ok || pop_ok;
    ctrl_o.list_we     = append;
    ctrl_o.entry_valid = pop_ok;
    ctrl_o.sat         = accum_ok && clip;
    cnt_addr_o         = pop_ok ? top_wide[ADDR_W-1:0] : key_wide[ADDR_W-1:0];
    cnt_data_o         = pop_ok ? '0 : new_count;
    list_addr_o        = total_i[ADDR_W-1:0];
    entry_key_o        = pop_ok ? top_key_i : '0;
    entry_total_o      = pop_ok ? old_count_i : '0;
    if (append) begin
      total_o   = total_i + TOT_W'(1);
      top_key_o = item_i.key;
    end else if (pop_ok) begin
      total_o   = total_i - TOT_W'(1);
      top_key_o = list_rd_i;
    end else begin
      total_o   = total_i;
      top_key_o = top_key_i;
    end
  end

endmodule

@@ hdl/sparse_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// sparse_accumulator_unit: sparse accumulator with occupancy list
// per-key saturating counts plus a stack of keys currently held
// ----------------------------------------------------------------------------
// usage
//   input stream: tuser is the opcode (0 accumulate, 1 drain), tdata carries
//   key and weight; every transaction yields exactly one output transaction
//   output stream: tuser flags a popped entry, tdata carries entry key and
//   total, distinct key count, set-empty and saturated flags
//   an input transaction is registered in the execute stage and then in the output register before output tvalid
//   throughput: one item per cycle while the output is not stalled; the count store has one read port
//   (read at accept) and one write port (written at execute), with a
//   bypass of the write that lands on the same edge as the read
//   reset: a clearing pass zeroes the count store, one entry per cycle,
//   over all KEY_RANGE entries; s_axis_tready stays low until it is done
//   stall: the output register plus the execute stage hold two items;
//   with m_axis_tready low the input is refused once both are full
// ----------------------------------------------------------------------------
module sparse_accumulator_unit #(
  parameter int KEY_RANGE  = 1024,
  parameter int COUNT_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [9:0] key, [25:10] weight, [31:26] zero
  input  logic [sacc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] opcode
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [9:0] entry_key, [41:10] entry_total, [52:42] distinct_count,
  // [53] set_empty, [54] saturated, [55] zero
  output logic [sacc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [0] entry_valid
  output logic                               m_axis_tuser
);
  import sacc_pkg::*;

  localparam int ADDR_W = $clog2(KEY_RANGE);
  localparam int TOT_W  = $clog2(KEY_RANGE + 1);

  // count store and seen-key stack
  logic [COUNT_BITS-1:0] counts [KEY_RANGE];
  logic [KEY_W-1:0]      seen   [KEY_RANGE];

  // clearing pass after reset
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;

  // committed list state
  logic [TOT_W-1:0]  total_q, total_d;
  logic [KEY_W-1:0]  top_key_q, top_key_d;

  // execute stage
  logic                  s_valid_q;
  item_t                 s_item_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic                  fwd_hit_q;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic [KEY_W-1:0]      list_rd_q;

  // output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_user_q;

  // handshake
  logic  adv;
  logic  commit;
  logic  accept;
  item_t in_item;

  // execute results
  ctrl_t                 ex_ctrl;
  logic [ADDR_W-1:0]     ex_cnt_addr;
  logic [COUNT_BITS-1:0] ex_cnt_data;
  logic [ADDR_W-1:0]     ex_list_addr;
  logic [TOT_W-1:0]      ex_total;
  logic [KEY_W-1:0]      ex_top_key;
  logic [KEY_W-1:0]      ex_entry_key;
  logic [COUNT_BITS-1:0] ex_entry_total;
  logic [COUNT_BITS-1:0] old_count;

  // memory ports
  logic                  cnt_we;
  logic [ADDR_W-1:0]     cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [ADDR_W-1:0]     cnt_ra;
  logic [ADDR_W-1:0]     list_ra;
  logic [WIDE_W-1:0]     in_key_wide;
  logic [WIDE_W-1:0]     top_d_wide;
  logic [TOT_W-1:0]      below_top;

  // result packing helpers
  logic [WIDE_CNT_W-1:0] total_wide;
  logic [WIDE_W-1:0]     dist_wide;
  logic [OUT_DATA_W-1:0] result;

  // the execute stage drains when the output register is free or taken
  assign adv           = !out_valid_q || m_axis_tready;
  assign commit        = s_valid_q && adv;
  assign s_axis_tready = !clr_busy_q && (!s_valid_q || adv);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_item.op     = op_e'(s_axis_tuser);
  assign in_item.key    = s_axis_tdata[KEY_W-1:0];
  assign in_item.weight = s_axis_tdata[KEY_W+WEIGHT_W-1:KEY_W];

  // a write on the accept edge is not seen by the read; bypass it
  assign old_count = fwd_hit_q ? fwd_data_q : cnt_rd_q;

  sacc_exec #(
    .KEY_RANGE  (KEY_RANGE),
    .COUNT_BITS (COUNT_BITS),
    .ADDR_W     (ADDR_W),
    .TOT_W      (TOT_W)
  ) u_exec (
    .item_i        (s_item_q),
    .old_count_i   (old_count),
    .total_i       (total_q),
    .top_key_i     (top_key_q),
    .list_rd_i     (list_rd_q),
    .ctrl_o        (ex_ctrl),
    .cnt_addr_o    (ex_cnt_addr),
    .cnt_data_o    (ex_cnt_data),
    .list_addr_o   (ex_list_addr),
    .total_o       (ex_total),
    .top_key_o     (ex_top_key),
    .entry_key_o   (ex_entry_key),
    .entry_total_o (ex_entry_total)
  );

  // list state after the item that commits on this edge
  assign total_d   = commit ? ex_total : total_q;
  assign top_key_d = commit ? ex_top_key : top_key_q;

  // count write port: clearing pass or execute
  assign cnt_we = clr_busy_q || (commit && ex_ctrl.cnt_we);
  assign cnt_wa = clr_busy_q ? clr_addr_q : ex_cnt_addr;
  assign cnt_wd = clr_busy_q ? '0 : ex_cnt_data;

  // read addresses for the incoming item: its own key, or the stack top for
  // a drain, together with the entry below the top that becomes the new top
  assign in_key_wide = WIDE_W'(in_item.key);
  assign top_d_wide  = WIDE_W'(top_key_d);
  assign cnt_ra      = (in_item.op == OP_DRAIN) ? top_d_wide[ADDR_W-1:0]
                                                : in_key_wide[ADDR_W-1:0];
  assign below_top   = total_d - TOT_W'(2);
  assign list_ra     = below_top[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      counts[cnt_wa] <= cnt_wd;
    end
    if (accept) begin
      cnt_rd_q <= counts[cnt_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && ex_ctrl.list_we) begin
      seen[ex_list_addr] <= s_item_q.key;
    end
    if (accept) begin
      list_rd_q <= seen[list_ra];
    end
  end

  // result fields
  assign total_wide = WIDE_CNT_W'(ex_entry_total);
  assign dist_wide  = WIDE_W'(ex_total);
  assign result = {1'b0,
                   ex_ctrl.sat,
                   (ex_total == '0),
                   dist_wide[DIST_W-1:0],
                   total_wide[ENTRY_TOT_W-1:0],
                   ex_entry_key};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      total_q     <= '0;
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(KEY_RANGE - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      total_q <= total_d;
      if (accept) begin
        s_valid_q <= 1'b1;
      end else if (commit) begin
        s_valid_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_key_q <= top_key_d;
    if (accept) begin
      s_item_q   <= in_item;
      fwd_hit_q  <= cnt_we && (cnt_wa == cnt_ra);
      fwd_data_q <= cnt_wd;
    end
    if (commit) begin
      out_data_q <= result;
      out_user_q <= ex_ctrl.entry_valid;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // no input while the count store is being cleared
  a_clear_blocks_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_busy_q |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  // a stalled execute stage keeps its item
  a_stage_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (s_valid_q && !adv) |=> s_valid_q)
    else $error("execute stage lost an item while stalled");

  // the stack never holds more keys than the key range
  a_total_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni) total_q <= TOT_W'(KEY_RANGE))
    else $error("seen list overflow");

  // a drain result never reports saturation
  a_drain_not_sat: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> !m_axis_tdata[54])
    else $error("drained entry flagged saturated");

endmodule
